/* src/wlsd_pkg.sv */
// ----------------------------------------------------------------------------
// wlsd_pkg
// Types and constants shared by the weighted LRU slot directory modules.
// ----------------------------------------------------------------------------
package wlsd_pkg;

  // Field widths fixed by the item formats.
  localparam int OP_W       = 2;
  localparam int SESSION_W  = 8;
  localparam int HISTORY_W  = 10;
  localparam int KIND_W     = 2;
  localparam int OUT_IDX_W  = 4;
  localparam int OUT_CNT_W  = 5;
  localparam int TICK_W     = 32;
  localparam int HITS_W     = 15;
  localparam int WEIGHT_W   = 10;
  localparam int ACTIVE_W   = 5;
  localparam int PROD_W     = HITS_W + WEIGHT_W;
  localparam int SCORE_W    = TICK_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_STORE      = 2'd0;
  localparam logic [OP_W-1:0] OP_RETRIEVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_INVAL_ONE  = 2'd2;
  localparam logic [OP_W-1:0] OP_INVAL_FROM = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_WEIGHT   = 2'd1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 10'd100;

  localparam logic [HITS_W-1:0] HITS_MAX = 15'h7FFF;
  localparam logic [TICK_W-1:0] TICK_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SESSION_W-1:0] session;
    logic [HISTORY_W-1:0] history_index;
    logic [KIND_W-1:0]    kind_in;
    logic                 with_payload;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] slot_index;
    logic [KIND_W-1:0]    kind_out;
    logic                 displaced;
    logic [OUT_CNT_W-1:0] cleared_count;
  } out_item_t;

  typedef struct packed {
    logic [SESSION_W-1:0] session;
    logic [HISTORY_W-1:0] history;
    logic [KIND_W-1:0]    kind;
    logic                 payload;
    logic [TICK_W-1:0]    last_use;
    logic [HITS_W-1:0]    hits;
  } slot_rec_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic skip;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } ctrl_sts_t;

endpackage

/* src/wlsd_ctrl.sv */
// ----------------------------------------------------------------------------
// wlsd_ctrl
// Sequencer: accepts an item, runs the slot scan, waits for the scan pipeline
// to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module wlsd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wlsd_pkg::ctrl_sts_t sts,
  output wlsd_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          // A store of kind none needs no scan.
          state_nxt = sts.skip ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

/* src/wlsd_datapath.sv */
// ----------------------------------------------------------------------------
// wlsd_datapath
// Slot memory, valid bits, configuration registers, the three-stage scan
// pipeline (read, score, select) and the output register.
// ----------------------------------------------------------------------------
module wlsd_datapath #(
  parameter int SLOTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wlsd_pkg::in_item_t                   in_data,
  input  logic                                 cfg_valid,
  input  logic [wlsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wlsd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output wlsd_pkg::out_item_t                  out_data,
  input  wlsd_pkg::ctrl_cmd_t                  cmd,
  output wlsd_pkg::ctrl_sts_t                  sts
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int NW    = (CNT_W > wlsd_pkg::ACTIVE_W) ? CNT_W : wlsd_pkg::ACTIVE_W;

  // Configuration.
  logic [wlsd_pkg::ACTIVE_W-1:0] active_r;
  logic [wlsd_pkg::WEIGHT_W-1:0] weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= wlsd_pkg::ACTIVE_RESET;
      weight_r <= wlsd_pkg::WEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == wlsd_pkg::CFG_ACTIVE_SLOTS) begin
        active_r <= cfg_data[wlsd_pkg::ACTIVE_W-1:0];
      end else if (cfg_index == wlsd_pkg::CFG_HIT_WEIGHT) begin
        weight_r <= cfg_data[wlsd_pkg::WEIGHT_W-1:0];
      end
    end
  end

  // Number of scanned slots: zero acts as one, large values clamp to SLOTS.
  logic [NW-1:0]    act_ext;
  logic [NW-1:0]    scan_n;
  logic [IDX_W-1:0] last_idx;

  always_comb begin
    act_ext = NW'(active_r);
    if (act_ext == '0) begin
      scan_n = NW'(1);
    end else if (act_ext > NW'(SLOTS)) begin
      scan_n = NW'(SLOTS);
    end else begin
      scan_n = act_ext;
    end
    last_idx = IDX_W'(scan_n - NW'(1));
  end

  // Item register and scan counter.
  wlsd_pkg::in_item_t item_r;
  logic [IDX_W-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.start) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  // Slot memory and valid bits.
  wlsd_pkg::slot_rec_t mem [0:SLOTS-1];
  wlsd_pkg::slot_rec_t rd_q;
  logic [SLOTS-1:0]    valid_r;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  wlsd_pkg::slot_rec_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.step) rd_q <= mem[cnt_r];
  end

  // Stage 1: entry read. Stage 2: match flags and score.
  logic             s1_v_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_v_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic             s2_valid_r;
  logic             s2_match_r;
  logic             s2_from_r;
  logic [wlsd_pkg::SCORE_W-1:0] s2_score_r;
  wlsd_pkg::slot_rec_t          s2_rec_r;

  logic                         s1_valid;
  logic                         s1_ses_eq;
  logic [wlsd_pkg::PROD_W-1:0]  s1_prod;
  logic [wlsd_pkg::SCORE_W-1:0] s1_score;

  always_comb begin
    s1_valid  = valid_r[s1_idx_r];
    s1_ses_eq = (rd_q.session == item_r.session);
    s1_prod   = wlsd_pkg::PROD_W'(rd_q.hits) * wlsd_pkg::PROD_W'(weight_r);
    s1_score  = wlsd_pkg::SCORE_W'(rd_q.last_use) + wlsd_pkg::SCORE_W'(s1_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.step;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) s1_idx_r <= cnt_r;
    if (s1_v_r) begin
      s2_idx_r   <= s1_idx_r;
      s2_valid_r <= s1_valid;
      s2_match_r <= s1_valid && s1_ses_eq && (rd_q.history == item_r.history_index);
      s2_from_r  <= s1_valid && s1_ses_eq && (rd_q.history >= item_r.history_index);
      s2_score_r <= s1_score;
      s2_rec_r   <= rd_q;
    end
  end

  // Stage 3: first match, first empty, lowest score, range clears.
  logic                         found_r;
  logic [IDX_W-1:0]             match_idx_r;
  wlsd_pkg::slot_rec_t          match_rec_r;
  logic                         empty_r;
  logic [IDX_W-1:0]             empty_idx_r;
  logic [IDX_W-1:0]             best_idx_r;
  logic [wlsd_pkg::SCORE_W-1:0] min_score_r;
  logic [CNT_W-1:0]             clr_cnt_r;
  logic [IDX_W-1:0]             clr_idx_r;
  logic                         from_clear;

  assign from_clear = s2_v_r && s2_from_r && (item_r.op == wlsd_pkg::OP_INVAL_FROM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      empty_r   <= 1'b0;
      clr_cnt_r <= '0;
      clr_idx_r <= '0;
    end else if (cmd.start) begin
      found_r   <= 1'b0;
      empty_r   <= 1'b0;
      clr_cnt_r <= '0;
      clr_idx_r <= '0;
    end else if (s2_v_r) begin
      if (s2_match_r && !found_r) found_r <= 1'b1;
      if (!s2_valid_r && !empty_r) empty_r <= 1'b1;
      if (from_clear) begin
        if (clr_cnt_r == '0) clr_idx_r <= s2_idx_r;
        clr_cnt_r <= clr_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      if (s2_match_r && !found_r) begin
        match_idx_r <= s2_idx_r;
        match_rec_r <= s2_rec_r;
      end
      if (!s2_valid_r && !empty_r) empty_idx_r <= s2_idx_r;
      // Slot zero seeds the minimum; a tie keeps the lower index.
      if ((s2_idx_r == '0) || (s2_score_r < min_score_r)) begin
        best_idx_r  <= s2_idx_r;
        min_score_r <= s2_score_r;
      end
    end
  end

  // Finish: choose the slot, update state and form the result.
  logic [wlsd_pkg::TICK_W-1:0] tick_r;
  logic [wlsd_pkg::TICK_W-1:0] tick_sat;
  logic                        tick_we;
  logic                        set_valid;
  logic                        clr_valid;
  logic [IDX_W-1:0]            res_idx;
  logic [IDX_W+wlsd_pkg::OUT_IDX_W-1:0] idx_wide;
  logic [CNT_W+wlsd_pkg::OUT_CNT_W-1:0] cnt_wide;
  wlsd_pkg::out_item_t         res;

  assign tick_sat = (tick_r == wlsd_pkg::TICK_MAX) ? tick_r
                                                   : tick_r + wlsd_pkg::TICK_W'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = match_idx_r;
    mem_wdata = match_rec_r;
    tick_we   = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    res_idx   = '0;
    cnt_wide  = '0;
    res       = '0;
    unique case (item_r.op)
      wlsd_pkg::OP_STORE: begin
        if (item_r.kind_in != wlsd_pkg::KIND_NONE) begin
          priority if (found_r) begin
            res_idx = match_idx_r;
          end else if (empty_r) begin
            res_idx = empty_idx_r;
          end else begin
            res_idx       = best_idx_r;
            res.displaced = 1'b1;
          end
          mem_we             = cmd.finish;
          mem_waddr          = res_idx;
          mem_wdata.session  = item_r.session;
          mem_wdata.history  = item_r.history_index;
          mem_wdata.kind     = item_r.kind_in;
          mem_wdata.payload  = item_r.with_payload;
          mem_wdata.last_use = tick_sat;
          mem_wdata.hits     = '0;
          tick_we            = cmd.finish;
          set_valid          = cmd.finish;
          res.hit            = 1'b1;
        end
      end
      wlsd_pkg::OP_RETRIEVE: begin
        if (found_r) begin
          res_idx            = match_idx_r;
          mem_we             = cmd.finish;
          mem_wdata.last_use = tick_sat;
          if (match_rec_r.hits != wlsd_pkg::HITS_MAX) begin
            mem_wdata.hits = match_rec_r.hits + wlsd_pkg::HITS_W'(1);
          end
          tick_we      = cmd.finish;
          res.hit      = match_rec_r.payload;
          res.kind_out = match_rec_r.kind;
        end
      end
      wlsd_pkg::OP_INVAL_ONE: begin
        if (found_r) begin
          res_idx   = match_idx_r;
          clr_valid = cmd.finish;
          cnt_wide  = (CNT_W + wlsd_pkg::OUT_CNT_W)'(1);
        end
      end
      wlsd_pkg::OP_INVAL_FROM: begin
        res_idx  = clr_idx_r;
        cnt_wide = (CNT_W + wlsd_pkg::OUT_CNT_W)'(clr_cnt_r);
      end
      default: res_idx = '0;
    endcase
    idx_wide          = (IDX_W + wlsd_pkg::OUT_IDX_W)'(res_idx);
    res.slot_index    = idx_wide[wlsd_pkg::OUT_IDX_W-1:0];
    res.cleared_count = cnt_wide[wlsd_pkg::OUT_CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (tick_we) begin
      tick_r <= tick_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (from_clear) valid_r[s2_idx_r] <= 1'b0;
      if (set_valid) valid_r[res_idx] <= 1'b1;
      if (clr_valid) valid_r[res_idx] <= 1'b0;
    end
  end

  // Output register.
  logic                out_valid_r;
  wlsd_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.skip      = (in_data.op == wlsd_pkg::OP_STORE) &&
                         (in_data.kind_in == wlsd_pkg::KIND_NONE);
  assign sts.scan_last = (cnt_r == last_idx);
  assign sts.pipe_busy = s1_v_r || s2_v_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

/* src/weighted_lru_slot_directory_unit.sv */
// ----------------------------------------------------------------------------
// weighted_lru_slot_directory_unit
// Tag directory of page slots keyed by session and history index, with
// weighted LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one operation item (store, retrieve, invalidate
//   one, invalidate from index). out_valid/out_stall return exactly one
//   result item per input item, in order. cfg_valid/cfg_ready write the
//   active slot count (index 0) and the hit weight (index 1); cfg_ready is
//   always high and writes belong to idle periods.
// Timing:
//   One item at a time. An item runs through the scan of its N slots and
//   the pipeline drain before its result reaches the result register, and
//   the next item is accepted only after that. A store of kind none skips
//   the scan. The pace is set by the slot memory, read one entry per cycle,
//   and the three-stage read/score/select scan pipeline.
// Reset:
//   All slots are empty, the tick is zero, active slots is 16 and the hit
//   weight is 100. The slot memory needs no clearing pass.
// Stall:
//   The result waits in the output register; the next item is accepted and
//   scanned meanwhile and holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module weighted_lru_slot_directory_unit #(
  parameter int SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wlsd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wlsd_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wlsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  wlsd_pkg::ctrl_cmd_t cmd;
  wlsd_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  wlsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wlsd_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* tb/tb_weighted_lru_slot_directory_unit.sv */
// ----------------------------------------------------------------------------
// tb_weighted_lru_slot_directory_unit
// Self-checking testbench for the weighted LRU slot directory. A behavioral
// copy of the directory predicts every result as its item is accepted. A
// sink process compares each returned item field by field, in order. Stimulus
// starts with short directed sequences and then runs randomized traffic over
// a small key pool under several register settings. Both handshakes idle at
// random, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_weighted_lru_slot_directory_unit;

  localparam int SLOTS           = 16;
  localparam int IDLE_PCT        = 38;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int STEADY_ITEMS    = 200;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [wlsd_pkg::KIND_W-1:0] KIND_DIR  = 2'd1;
  localparam logic [wlsd_pkg::KIND_W-1:0] KIND_TEXT = 2'd2;
  localparam logic [wlsd_pkg::KIND_W-1:0] KIND_HTML = 2'd3;

  // Indexes that select no register; writes to them must be ignored.
  localparam logic [wlsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [wlsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  wlsd_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  wlsd_pkg::out_item_t             out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [wlsd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wlsd_pkg::CFG_DATA_W-1:0] cfg_data;

  logic hold_request;
  logic hold_active;
  logic steady_flow;

  // Behavioral copy of the directory and its registers.
  logic                           dir_valid   [SLOTS];
  logic [wlsd_pkg::SESSION_W-1:0] dir_session [SLOTS];
  logic [wlsd_pkg::HISTORY_W-1:0] dir_history [SLOTS];
  logic [wlsd_pkg::KIND_W-1:0]    dir_kind    [SLOTS];
  logic                           dir_payload [SLOTS];
  logic [wlsd_pkg::TICK_W-1:0]    dir_time    [SLOTS];
  logic [wlsd_pkg::HITS_W-1:0]    dir_hits    [SLOTS];
  logic [wlsd_pkg::TICK_W-1:0]    dir_tick;
  logic [wlsd_pkg::ACTIVE_W-1:0]  dir_active;
  logic [wlsd_pkg::WEIGHT_W-1:0]  dir_weight;

  wlsd_pkg::out_item_t pending_results[$];

  logic [wlsd_pkg::SESSION_W-1:0] key_sessions [4];
  logic [wlsd_pkg::HISTORY_W-1:0] key_history_base;

  int fail_count       = 0;
  int items_sent       = 0;
  int results_checked  = 0;
  int settings_written = 0;

  weighted_lru_slot_directory_unit #(.SLOTS(SLOTS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic wlsd_pkg::out_item_t predict_directory(input wlsd_pkg::in_item_t item);
    wlsd_pkg::out_item_t res;
    int                  n;
    int                  i;
    int                  found;
    int                  pick;
    logic                empty_seen;
    logic [63:0]         score;
    logic [63:0]         low_score;
    res = '0;
    n = (dir_active == 0) ? 1 : (dir_active > SLOTS) ? SLOTS : int'(dir_active);
    found = -1;
    for (i = 0; i < n; i++) begin
      if (found < 0 && dir_valid[i] && dir_session[i] == item.session &&
          dir_history[i] == item.history_index) found = i;
    end
    case (item.op)
      wlsd_pkg::OP_STORE: begin
        if (item.kind_in != wlsd_pkg::KIND_NONE) begin
          if (found >= 0) begin
            pick = found;
          end else begin
            // First empty slot wins; otherwise the lowest score, ties low.
            pick = 0;
            empty_seen = 1'b0;
            low_score = '1;
            for (i = 0; i < n; i++) begin
              if (!empty_seen) begin
                if (!dir_valid[i]) begin
                  pick = i;
                  empty_seen = 1'b1;
                end else begin
                  score = 64'(dir_time[i]) + 64'(dir_hits[i]) * 64'(dir_weight);
                  if (score < low_score) begin
                    low_score = score;
                    pick = i;
                  end
                end
              end
            end
            res.displaced = dir_valid[pick];
          end
          if (dir_tick != wlsd_pkg::TICK_MAX) dir_tick = dir_tick + 1'b1;
          dir_valid[pick]   = 1'b1;
          dir_session[pick] = item.session;
          dir_history[pick] = item.history_index;
          dir_kind[pick]    = item.kind_in;
          dir_payload[pick] = item.with_payload;
          dir_time[pick]    = dir_tick;
          dir_hits[pick]    = '0;
          res.hit           = 1'b1;
          res.slot_index    = pick[wlsd_pkg::OUT_IDX_W-1:0];
        end
      end
      wlsd_pkg::OP_RETRIEVE: begin
        if (found >= 0) begin
          if (dir_tick != wlsd_pkg::TICK_MAX) dir_tick = dir_tick + 1'b1;
          dir_time[found] = dir_tick;
          if (dir_hits[found] != wlsd_pkg::HITS_MAX)
            dir_hits[found] = dir_hits[found] + 1'b1;
          res.kind_out   = dir_kind[found];
          res.hit        = dir_payload[found];
          res.slot_index = found[wlsd_pkg::OUT_IDX_W-1:0];
        end
      end
      wlsd_pkg::OP_INVAL_ONE: begin
        if (found >= 0) begin
          dir_valid[found]  = 1'b0;
          dir_hits[found]   = '0;
          res.slot_index    = found[wlsd_pkg::OUT_IDX_W-1:0];
          res.cleared_count = 5'd1;
        end
      end
      wlsd_pkg::OP_INVAL_FROM: begin
        for (i = 0; i < n; i++) begin
          if (dir_valid[i] && dir_session[i] == item.session &&
              dir_history[i] >= item.history_index) begin
            if (res.cleared_count == 0) res.slot_index = i[wlsd_pkg::OUT_IDX_W-1:0];
            dir_valid[i] = 1'b0;
            dir_hits[i]  = '0;
            res.cleared_count = res.cleared_count + 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic wlsd_pkg::in_item_t make_item(
      input logic [wlsd_pkg::OP_W-1:0]      op,
      input logic [wlsd_pkg::SESSION_W-1:0] session,
      input logic [wlsd_pkg::HISTORY_W-1:0] history,
      input logic [wlsd_pkg::KIND_W-1:0]    kind,
      input logic                           payload);
    wlsd_pkg::in_item_t item;
    item.op            = op;
    item.session       = session;
    item.history_index = history;
    item.kind_in       = kind;
    item.with_payload  = payload;
    return item;
  endfunction

  // Mostly keys from a small pool so that stores, hits and evictions meet;
  // now and then a key from the full range.
  function automatic wlsd_pkg::in_item_t make_random_item();
    wlsd_pkg::in_item_t item;
    int                 roll;
    roll = $urandom_range(99);
    item.op = (roll < 38) ? wlsd_pkg::OP_STORE : (roll < 72) ? wlsd_pkg::OP_RETRIEVE :
              (roll < 86) ? wlsd_pkg::OP_INVAL_ONE : wlsd_pkg::OP_INVAL_FROM;
    item.session = ($urandom_range(9) == 0) ? wlsd_pkg::SESSION_W'($urandom) :
                   key_sessions[$urandom_range(3)];
    if ($urandom_range(9) == 0)
      item.history_index = wlsd_pkg::HISTORY_W'($urandom);
    else if (item.op == wlsd_pkg::OP_INVAL_FROM && $urandom_range(1) == 1)
      item.history_index = key_history_base + wlsd_pkg::HISTORY_W'($urandom_range(2));
    else
      item.history_index = key_history_base + wlsd_pkg::HISTORY_W'($urandom_range(7));
    if (item.op == wlsd_pkg::OP_STORE && $urandom_range(99) >= 6)
      item.kind_in = wlsd_pkg::KIND_W'($urandom_range(1, 3));
    else
      item.kind_in = wlsd_pkg::KIND_W'($urandom);
    item.with_payload = 1'($urandom);
    return item;
  endfunction

  task automatic pick_key_pool();
    int k;
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(3) == 0)
        key_sessions[k] = ($urandom_range(1) == 1) ? 8'd255 : 8'd0;
      else
        key_sessions[k] = wlsd_pkg::SESSION_W'($urandom);
    end
    if ($urandom_range(3) == 0)
      key_history_base = ($urandom_range(1) == 1) ? 10'd1016 : 10'd0;
    else
      key_history_base = wlsd_pkg::HISTORY_W'($urandom_range(1016));
  endtask

  task automatic send_item(input wlsd_pkg::in_item_t item);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 24);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_directory(item));
    items_sent++;
  endtask

  task automatic write_reg(input logic [wlsd_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [wlsd_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == wlsd_pkg::CFG_ACTIVE_SLOTS) dir_active = value[wlsd_pkg::ACTIVE_W-1:0];
    else if (idx == wlsd_pkg::CFG_HIT_WEIGHT) dir_weight = value;
    settings_written++;
    @(posedge clk);
  endtask

  // Every item yields a result, so an empty queue plus a short settle means
  // the block is idle.
  task automatic wait_idle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_ops();
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd0, 10'd0, KIND_DIR, 1'b1));
    send_item(make_item(wlsd_pkg::OP_RETRIEVE, 8'd0, 10'd0, wlsd_pkg::KIND_NONE, 1'b0));
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd255, 10'd1023, KIND_HTML, 1'b0));
    send_item(make_item(wlsd_pkg::OP_RETRIEVE, 8'd255, 10'd1023, KIND_HTML, 1'b1));
    // A store of kind none leaves everything untouched.
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd9, 10'd9, wlsd_pkg::KIND_NONE, 1'b1));
    send_item(make_item(wlsd_pkg::OP_RETRIEVE, 8'd9, 10'd9, wlsd_pkg::KIND_NONE, 1'b0));
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd0, 10'd0, KIND_TEXT, 1'b0));
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd255, 10'd1021, KIND_TEXT, 1'b1));
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd255, 10'd1022, KIND_DIR, 1'b1));
    send_item(make_item(wlsd_pkg::OP_INVAL_FROM, 8'd255, 10'd1022,
                        wlsd_pkg::KIND_NONE, 1'b0));
    send_item(make_item(wlsd_pkg::OP_INVAL_ONE, 8'd255, 10'd1021,
                        wlsd_pkg::KIND_NONE, 1'b0));
    send_item(make_item(wlsd_pkg::OP_INVAL_ONE, 8'd255, 10'd1021,
                        wlsd_pkg::KIND_NONE, 1'b0));
    send_item(make_item(wlsd_pkg::OP_INVAL_FROM, 8'd77, 10'd0, wlsd_pkg::KIND_NONE, 1'b0));
    send_item(make_item(wlsd_pkg::OP_RETRIEVE, 8'd0, 10'd0, wlsd_pkg::KIND_NONE, 1'b0));
  endtask

  task automatic test_replacement();
    wait_idle();
    // Upper data bits above the active count field must be dropped.
    write_reg(wlsd_pkg::CFG_ACTIVE_SLOTS, 10'h3E3);
    write_reg(wlsd_pkg::CFG_HIT_WEIGHT, 10'd0);
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd1, 10'd1, KIND_DIR, 1'b1));
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd1, 10'd2, KIND_TEXT, 1'b1));
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd1, 10'd3, KIND_HTML, 1'b1));
    send_item(make_item(wlsd_pkg::OP_RETRIEVE, 8'd1, 10'd1, wlsd_pkg::KIND_NONE, 1'b0));
    wait_idle();
    write_reg(wlsd_pkg::CFG_HIT_WEIGHT, 10'd1023);
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd1, 10'd4, KIND_DIR, 1'b0));
    wait_idle();
    // A count of zero scans one slot; slots past the count keep their data.
    write_reg(wlsd_pkg::CFG_ACTIVE_SLOTS, 10'h3E0);
    send_item(make_item(wlsd_pkg::OP_STORE, 8'd2, 10'd5, KIND_TEXT, 1'b1));
    send_item(make_item(wlsd_pkg::OP_RETRIEVE, 8'd1, 10'd1, wlsd_pkg::KIND_NONE, 1'b0));
    wait_idle();
    write_reg(CFG_SPARE_A, wlsd_pkg::CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_B, wlsd_pkg::CFG_DATA_W'($urandom));
    write_reg(wlsd_pkg::CFG_ACTIVE_SLOTS, 10'h01F);
    send_item(make_item(wlsd_pkg::OP_RETRIEVE, 8'd1, 10'd1, wlsd_pkg::KIND_NONE, 1'b0));
    send_item(make_item(wlsd_pkg::OP_RETRIEVE, 8'd1, 10'd2, wlsd_pkg::KIND_NONE, 1'b0));
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    pick_key_pool();
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    repeat (8) send_item(make_random_item());
  endtask

  task automatic test_random_mixed();
    int                            p;
    logic [wlsd_pkg::ACTIVE_W-1:0] act;
    logic [wlsd_pkg::WEIGHT_W-1:0] wt;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       begin act = wlsd_pkg::ACTIVE_RESET; wt = wlsd_pkg::WEIGHT_RESET; end
        1:       begin act = 5'd0;  wt = 10'd0;    end
        2:       begin act = 5'd31; wt = 10'd1023; end
        3:       begin act = 5'd1;  wt = 10'd1;    end
        4:       begin act = 5'd2;  wt = 10'd3;    end
        5:       begin act = 5'd16; wt = 10'd0;    end
        6:       begin act = 5'd8;  wt = 10'd1023; end
        default: begin
          act = wlsd_pkg::ACTIVE_W'($urandom);
          wt  = wlsd_pkg::WEIGHT_W'($urandom);
        end
      endcase
      wait_idle();
      write_reg(wlsd_pkg::CFG_ACTIVE_SLOTS, {5'($urandom), act});
      write_reg(wlsd_pkg::CFG_HIT_WEIGHT, wt);
      pick_key_pool();
      repeat (ITEMS_PER_PHASE) send_item(make_random_item());
    end
  endtask

  task automatic test_steady_stream();
    wait_idle();
    write_reg(wlsd_pkg::CFG_ACTIVE_SLOTS, 10'd16);
    write_reg(wlsd_pkg::CFG_HIT_WEIGHT, wlsd_pkg::WEIGHT_W'($urandom_range(1, 200)));
    pick_key_pool();
    steady_flow <= 1'b1;
    @(posedge clk);
    repeat (STEADY_ITEMS) send_item(make_random_item());
    wait_idle();
    steady_flow <= 1'b0;
  endtask

  initial begin : result_sink
    wlsd_pkg::out_item_t want;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("ERROR: result item with nothing expected: hit=%0d slot=%0d",
                     out_data.hit, out_data.slot_index);
        end else begin
          want = pending_results.pop_front();
          if (out_data.hit !== want.hit || out_data.slot_index !== want.slot_index ||
              out_data.kind_out !== want.kind_out || out_data.displaced !== want.displaced ||
              out_data.cleared_count !== want.cleared_count) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"ERROR: result %0d expected hit=%0d slot=%0d kind=%0d disp=%0d ",
                        "cleared=%0d, got hit=%0d slot=%0d kind=%0d disp=%0d cleared=%0d"},
                       results_checked, want.hit, want.slot_index, want.kind_out,
                       want.displaced, want.cleared_count, out_data.hit,
                       out_data.slot_index, out_data.kind_out, out_data.displaced,
                       out_data.cleared_count);
          end
        end
      end
      out_stall <= hold_active || (!steady_flow && $urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin : output_hold_off
    int k;
    hold_active <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_active <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_active <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int i;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    hold_request <= 1'b0;
    steady_flow  <= 1'b0;
    for (i = 0; i < SLOTS; i++) begin
      dir_valid[i]   = 1'b0;
      dir_session[i] = '0;
      dir_history[i] = '0;
      dir_kind[i]    = '0;
      dir_payload[i] = 1'b0;
      dir_time[i]    = '0;
      dir_hits[i]    = '0;
    end
    dir_tick   = '0;
    dir_active = wlsd_pkg::ACTIVE_RESET;
    dir_weight = wlsd_pkg::WEIGHT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_replacement();
    test_output_backpressure();
    test_random_mixed();
    test_steady_stream();
    wait_idle();

    if (pending_results.size() != 0) begin
      $display("ERROR: %0d result items never arrived", pending_results.size());
      fail_count += pending_results.size();
    end
    $display("Sent %0d items and checked %0d results across %0d register writes.",
             items_sent, results_checked, settings_written);
    $display("Traffic mixed stores, lookups and both invalidations under eviction and stalls.");
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
